[rtl/mwb_pkg.sv]
// shared constants and types for the bilinear mesh warp map core
package mwb_pkg;

  localparam int GRID_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;
  localparam int CELL_MAX_DEF    = 256;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int IDX_W      = 6;
  localparam int OFS_W      = 8;
  localparam int BND_W      = 12;
  localparam int GRID_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic valid;
    logic err;
  } mwb_ctl_t;

endpackage

[rtl/mwb_ram.sv]
// generic single write port ram with registered read
module mwb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mwb_mesh.sv]
// mesh storage, corner fetch and cell checks
module mwb_mesh #(
  parameter int GRID_POINTS = mwb_pkg::GRID_POINTS_DEF,
  parameter int COORD_BITS  = mwb_pkg::COORD_BITS_DEF,
  parameter int CELL_MAX    = mwb_pkg::CELL_MAX_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic                                        acc,
  input  logic                                        cmd,
  input  logic [mwb_pkg::IDX_W-1:0]                   ci,
  input  logic [mwb_pkg::IDX_W-1:0]                   ri,
  input  logic [COORD_BITS-1:0]                       pt_x,
  input  logic [COORD_BITS-1:0]                       pt_y,
  input  logic [mwb_pkg::OFS_W-1:0]                   ofs_m,
  input  logic [mwb_pkg::OFS_W-1:0]                   ofs_n,
  input  logic [mwb_pkg::BND_W-1:0]                   bnd_x,
  input  logic [mwb_pkg::BND_W-1:0]                   bnd_y,
  input  logic [mwb_pkg::GRID_W-1:0]                  grid_cols,
  input  logic [mwb_pkg::GRID_W-1:0]                  grid_rows,
  output mwb_pkg::mwb_ctl_t                           ctl_o,
  output logic [3:0][COORD_BITS-1:0]                  cx_o,
  output logic [3:0][COORD_BITS-1:0]                  cy_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               m_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               n_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               wm_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               hn_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               w_o,
  output logic [$clog2(CELL_MAX+1)-1:0]               h_o,
  output logic [COORD_BITS-1:0]                       map_col_o,
  output logic [COORD_BITS-1:0]                       map_row_o
);
  import mwb_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int DW     = $clog2(CELL_MAX + 1);
  localparam int ADDR_W = $clog2(GRID_POINTS * GRID_POINTS);
  localparam int GC_W   = ($clog2(GRID_POINTS + 1) > GRID_W) ? $clog2(GRID_POINTS + 1) : GRID_W;
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(GRID_POINTS);
  localparam logic [GC_W-1:0]   GP_LIM   = GC_W'(GRID_POINTS);

  logic [IDX_W:0]      ci1, ri1;
  logic [GC_W-1:0]     gc, gr;
  logic                range_bad, we;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr [8];
  logic [2*CW-1:0]     rd [8];
  logic [2*CW-1:0]     wdata;
  logic                re;

  mwb_ctl_t            s1_ctl_r, s1_ctl_nxt;
  logic [OFS_W-1:0]    s1_m_r, s1_n_r;

  logic [CW-1:0]       x0, x1, y0, y1, wd, hd;
  logic                bad;

  mwb_ctl_t            s2_ctl_r;
  logic [3:0][CW-1:0]  cx_r, cy_r;
  logic [DW-1:0]       m_r, n_r, wm_r, hn_r, w_r, h_r;
  logic [CW-1:0]       map_col_r, map_row_r;

  // stage 0: index math, range check, writes and reads
  always_comb begin
    ci1 = {1'b0, ci} + 1'b1;
    ri1 = {1'b0, ri} + 1'b1;
    gc  = (GC_W'(grid_cols) < GP_LIM) ? GC_W'(grid_cols) : GP_LIM;
    gr  = (GC_W'(grid_rows) < GP_LIM) ? GC_W'(grid_rows) : GP_LIM;
    range_bad = (GC_W'(ci1) >= gc) || (GC_W'(ri1) >= gr);
    we    = acc && (cmd == CMD_LOAD) && (32'(ci) < 32'(GRID_POINTS))
            && (32'(ri) < 32'(GRID_POINTS));
    re    = acc && (cmd == CMD_COMPUTE);
    waddr = ADDR_W'(ADDR_W'(ri) * ROW_STEP + ADDR_W'(ci));
    wdata = {pt_y, pt_x};
    raddr[0] = ADDR_W'(ci);
    raddr[1] = ADDR_W'(ci1);
    raddr[2] = ADDR_W'(ADDR_W'(ri) * ROW_STEP);
    raddr[3] = ADDR_W'(ADDR_W'(ri1) * ROW_STEP);
    raddr[4] = ADDR_W'(ADDR_W'(ri) * ROW_STEP + ADDR_W'(ci));
    raddr[5] = ADDR_W'(ADDR_W'(ri) * ROW_STEP + ADDR_W'(ci1));
    raddr[6] = ADDR_W'(ADDR_W'(ri1) * ROW_STEP + ADDR_W'(ci));
    raddr[7] = ADDR_W'(ADDR_W'(ri1) * ROW_STEP + ADDR_W'(ci1));
    s1_ctl_nxt.valid = re;
    s1_ctl_nxt.err   = range_bad;
  end

  // one replica per read port, all written together
  for (genvar k = 0; k < 8; k++) begin : g_ram
    mwb_ram #(
      .WIDTH(2 * CW),
      .DEPTH(GRID_POINTS * GRID_POINTS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (re),
      .raddr(raddr[k]),
      .rdata(rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r <= ofs_m;
      s1_n_r <= ofs_n;
    end
  end

  // stage 1: cell size and offset checks
  always_comb begin
    x0 = rd[0][CW-1:0];
    x1 = rd[1][CW-1:0];
    y0 = rd[2][2*CW-1:CW];
    y1 = rd[3][2*CW-1:CW];
    wd = x1 - x0;
    hd = y1 - y0;
    bad = s1_ctl_r.err || (x1 <= x0) || (y1 <= y0)
          || (32'(wd) > 32'(CELL_MAX)) || (32'(hd) > 32'(CELL_MAX))
          || (32'(s1_m_r) >= 32'(wd)) || (32'(s1_n_r) >= 32'(hd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (en) begin
      s2_ctl_r.valid <= s1_ctl_r.valid;
      s2_ctl_r.err   <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        cx_r[k] <= rd[4+k][CW-1:0];
        cy_r[k] <= rd[4+k][2*CW-1:CW];
      end
      m_r  <= DW'(s1_m_r);
      n_r  <= DW'(s1_n_r);
      w_r  <= DW'(wd);
      h_r  <= DW'(hd);
      wm_r <= DW'(wd) - DW'(s1_m_r);
      hn_r <= DW'(hd) - DW'(s1_n_r);
      map_col_r <= x0 + CW'(s1_m_r) - CW'(bnd_x);
      map_row_r <= y0 + CW'(s1_n_r) - CW'(bnd_y);
    end
  end

  assign ctl_o     = s2_ctl_r;
  assign cx_o      = cx_r;
  assign cy_o      = cy_r;
  assign m_o       = m_r;
  assign n_o       = n_r;
  assign wm_o      = wm_r;
  assign hn_o      = hn_r;
  assign w_o       = w_r;
  assign h_o       = h_r;
  assign map_col_o = map_col_r;
  assign map_row_o = map_row_r;

endmodule

[rtl/mwb_blend.sv]
// two multiply stages of the bilinear blend
module mwb_blend #(
  parameter int COORD_BITS = mwb_pkg::COORD_BITS_DEF,
  parameter int CELL_MAX   = mwb_pkg::CELL_MAX_DEF,
  parameter int SW         = 2 * mwb_pkg::COORD_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  mwb_pkg::mwb_ctl_t                                      ctl_i,
  input  logic [3:0][COORD_BITS-1:0]                             cx_i,
  input  logic [3:0][COORD_BITS-1:0]                             cy_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          m_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          n_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          wm_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          hn_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          w_i,
  input  logic [$clog2(CELL_MAX+1)-1:0]                          h_i,
  input  logic [SW-1:0]                                          side_i,
  output mwb_pkg::mwb_ctl_t                                      ctl_o,
  output logic [COORD_BITS+2*$clog2(CELL_MAX+1)+1:0]             num_x_o,
  output logic [COORD_BITS+2*$clog2(CELL_MAX+1)+1:0]             num_y_o,
  output logic [2*$clog2(CELL_MAX+1)-1:0]                        den_o,
  output logic [SW-1:0]                                          side_o
);
  import mwb_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = $clog2(CELL_MAX + 1);
  localparam int TW    = CW + DW + 1;
  localparam int NW    = TW + DW + 1;
  localparam int DEN_W = 2 * DW;

  mwb_ctl_t         a_ctl_r, b_ctl_r;
  logic [TW-1:0]    top_x_r, bot_x_r, top_y_r, bot_y_r;
  logic [DW-1:0]    a_n_r, a_hn_r;
  logic [DEN_W-1:0] a_den_r, b_den_r;
  logic [SW-1:0]    a_side_r, b_side_r;
  logic [NW-1:0]    num_x_r, num_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= ctl_i;
      b_ctl_r <= a_ctl_r;
    end
  end

  // horizontal blend of top and bottom edges, cell area
  always_ff @(posedge clk) begin
    if (en) begin
      top_x_r  <= TW'(cx_i[0]) * TW'(wm_i) + TW'(cx_i[1]) * TW'(m_i);
      bot_x_r  <= TW'(cx_i[2]) * TW'(wm_i) + TW'(cx_i[3]) * TW'(m_i);
      top_y_r  <= TW'(cy_i[0]) * TW'(wm_i) + TW'(cy_i[1]) * TW'(m_i);
      bot_y_r  <= TW'(cy_i[2]) * TW'(wm_i) + TW'(cy_i[3]) * TW'(m_i);
      a_den_r  <= DEN_W'(w_i) * DEN_W'(h_i);
      a_n_r    <= n_i;
      a_hn_r   <= hn_i;
      a_side_r <= side_i;
    end
  end

  // vertical blend
  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r  <= NW'(top_x_r) * NW'(a_hn_r) + NW'(bot_x_r) * NW'(a_n_r);
      num_y_r  <= NW'(top_y_r) * NW'(a_hn_r) + NW'(bot_y_r) * NW'(a_n_r);
      b_den_r  <= a_den_r;
      b_side_r <= a_side_r;
    end
  end

  assign ctl_o   = b_ctl_r;
  assign num_x_o = num_x_r;
  assign num_y_o = num_y_r;
  assign den_o   = b_den_r;
  assign side_o  = b_side_r;

endmodule

[rtl/mwb_divider.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes
module mwb_divider #(
  parameter int NW    = 32,
  parameter int DEN_W = 18,
  parameter int QW    = 20,
  parameter int FB    = 8,
  parameter int SW    = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  mwb_pkg::mwb_ctl_t ctl_i,
  input  logic [NW-1:0]     num_x_i,
  input  logic [NW-1:0]     num_y_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SW-1:0]     side_i,
  output mwb_pkg::mwb_ctl_t ctl_o,
  output logic [QW-1:0]     qx_o,
  output logic [QW-1:0]     qy_o,
  output logic [SW-1:0]     side_o
);
  import mwb_pkg::*;

  localparam int DVW = NW + FB + 1;
  localparam int RW  = DEN_W + 1;

  logic [DVW-1:0]   dx, dy;
  mwb_ctl_t         ctl_r  [QW+1];
  logic [RW-1:0]    rx_r   [QW+1];
  logic [RW-1:0]    ry_r   [QW+1];
  logic [QW-1:0]    lx_r   [QW+1];
  logic [QW-1:0]    ly_r   [QW+1];
  logic [DEN_W-1:0] den_r  [QW+1];
  logic [SW-1:0]    side_r [QW+1];

  // rounding: add half the divisor before dividing
  always_comb begin
    dx = (DVW'(num_x_i) << FB) + DVW'(den_i >> 1);
    dy = (DVW'(num_y_i) << FB) + DVW'(den_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]   <= RW'(dx[DVW-1:QW]);
      ry_r[0]   <= RW'(dy[DVW-1:QW]);
      lx_r[0]   <= dx[QW-1:0];
      ly_r[0]   <= dy[QW-1:0];
      den_r[0]  <= den_i;
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] tx, ty;
    logic          bx, by;

    always_comb begin
      tx = {rx_r[k][RW-2:0], lx_r[k][QW-1]};
      ty = {ry_r[k][RW-2:0], ly_r[k][QW-1]};
      bx = (tx >= RW'(den_r[k]));
      by = (ty >= RW'(den_r[k]));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1]   <= bx ? (tx - RW'(den_r[k])) : tx;
        ry_r[k+1]   <= by ? (ty - RW'(den_r[k])) : ty;
        lx_r[k+1]   <= {lx_r[k][QW-2:0], bx};
        ly_r[k+1]   <= {ly_r[k][QW-2:0], by};
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign ctl_o  = ctl_r[QW];
  assign qx_o   = lx_r[QW];
  assign qy_o   = ly_r[QW];
  assign side_o = side_r[QW];

endmodule

[rtl/mesh_warp_bilinear_map_core.sv]
// top level of the bilinear mesh warp map core
//
// channel  dir  tdata fields (low bit up)                              tuser
// in_      in   col_index, row_index, point_x, point_y, offset_m, _n   cmd
// out_     out  map_col, map_row, warped_x, warped_y                   status
// cfg_     in   write enable, register index, write data               -
//
// one item per cycle while the output is not stalled; a compute result passes the
// mesh stages, the blend stages, the one-bit-per-stage divider and the output register
// loads write the eight mesh ram replicas at the transfer edge and give no result
// reset clears valid bits and boundary regs, sets grid cols/rows to 2; the mesh holds nothing until loaded
// a stalled output freezes the whole pipeline and in_tready drops with it
module mesh_warp_bilinear_map_core #(
  parameter int GRID_POINTS = mwb_pkg::GRID_POINTS_DEF,
  parameter int COORD_BITS  = mwb_pkg::COORD_BITS_DEF,
  parameter int CELL_MAX    = mwb_pkg::CELL_MAX_DEF,
  parameter int FRAC_BITS   = mwb_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // col_index, row_index, point_x, point_y, offset_m, offset_n
  input  logic [((2*mwb_pkg::IDX_W+2*COORD_BITS+2*mwb_pkg::OFS_W+7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // map_col, map_row, warped_x, warped_y
  output logic [((4*COORD_BITS+2*FRAC_BITS+7)/8)*8-1:0] out_tdata,
  // status
  output logic                                   out_tuser,
  input  logic                                   cfg_we,
  input  logic [mwb_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [mwb_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import mwb_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int DW     = $clog2(CELL_MAX + 1);
  localparam int NW     = CW + 2 * DW + 2;
  localparam int DEN_W  = 2 * DW;
  localparam int QW     = CW + FRAC_BITS;
  localparam int SW     = 2 * CW;
  localparam int OUT_W  = ((4 * CW + 2 * FRAC_BITS + 7) / 8) * 8;
  localparam int PAY_W  = 2 * CW + 2 * QW;
  localparam int P_ROW  = IDX_W;
  localparam int P_PX   = 2 * IDX_W;
  localparam int P_PY   = P_PX + CW;
  localparam int P_M    = P_PY + CW;
  localparam int P_N    = P_M + OFS_W;

  logic [BND_W-1:0]  bnd_x_r, bnd_y_r;
  logic [GRID_W-1:0] gcols_r, grows_r;

  logic              en, acc;

  mwb_ctl_t           m_ctl, b_ctl, d_ctl;
  logic [3:0][CW-1:0] cx, cy;
  logic [DW-1:0]      m_v, n_v, wm_v, hn_v, w_v, h_v;
  logic [CW-1:0]      map_col, map_row;
  logic [NW-1:0]      num_x, num_y;
  logic [DEN_W-1:0]   den;
  logic [SW-1:0]      b_side, d_side;
  logic [QW-1:0]      qx, qy;

  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;
  logic               out_tuser_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_x_r <= '0;
      bnd_y_r <= '0;
      gcols_r <= GRID_W'(2);
      grows_r <= GRID_W'(2);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BOUNDARY_X: bnd_x_r <= cfg_wdata[BND_W-1:0];
        REG_BOUNDARY_Y: bnd_y_r <= cfg_wdata[BND_W-1:0];
        REG_GRID_COLS:  gcols_r <= cfg_wdata[GRID_W-1:0];
        REG_GRID_ROWS:  grows_r <= cfg_wdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  mwb_mesh #(
    .GRID_POINTS(GRID_POINTS),
    .COORD_BITS (COORD_BITS),
    .CELL_MAX   (CELL_MAX)
  ) u_mesh (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .acc      (acc),
    .cmd      (in_tuser),
    .ci       (in_tdata[IDX_W-1:0]),
    .ri       (in_tdata[P_ROW+IDX_W-1:P_ROW]),
    .pt_x     (in_tdata[P_PX+CW-1:P_PX]),
    .pt_y     (in_tdata[P_PY+CW-1:P_PY]),
    .ofs_m    (in_tdata[P_M+OFS_W-1:P_M]),
    .ofs_n    (in_tdata[P_N+OFS_W-1:P_N]),
    .bnd_x    (bnd_x_r),
    .bnd_y    (bnd_y_r),
    .grid_cols(gcols_r),
    .grid_rows(grows_r),
    .ctl_o    (m_ctl),
    .cx_o     (cx),
    .cy_o     (cy),
    .m_o      (m_v),
    .n_o      (n_v),
    .wm_o     (wm_v),
    .hn_o     (hn_v),
    .w_o      (w_v),
    .h_o      (h_v),
    .map_col_o(map_col),
    .map_row_o(map_row)
  );

  mwb_blend #(
    .COORD_BITS(COORD_BITS),
    .CELL_MAX  (CELL_MAX),
    .SW        (SW)
  ) u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (m_ctl),
    .cx_i   (cx),
    .cy_i   (cy),
    .m_i    (m_v),
    .n_i    (n_v),
    .wm_i   (wm_v),
    .hn_i   (hn_v),
    .w_i    (w_v),
    .h_i    (h_v),
    .side_i ({map_row, map_col}),
    .ctl_o  (b_ctl),
    .num_x_o(num_x),
    .num_y_o(num_y),
    .den_o  (den),
    .side_o (b_side)
  );

  mwb_divider #(
    .NW   (NW),
    .DEN_W(DEN_W),
    .QW   (QW),
    .FB   (FRAC_BITS),
    .SW   (SW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (b_ctl),
    .num_x_i(num_x),
    .num_y_i(num_y),
    .den_i  (den),
    .side_i (b_side),
    .ctl_o  (d_ctl),
    .qx_o   (qx),
    .qy_o   (qy),
    .side_o (d_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= d_ctl.valid;
    end
  end

  // error results carry zero payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser_r <= d_ctl.err;
      out_tdata_r <= d_ctl.err ? '0 : OUT_W'({qy, qx, d_side});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[PAY_W-1:0] == '0)
    else $error("error result with nonzero payload");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
